>>> rtl/lehmer_range_random_macros.svh
// Assertion macros for the lehmer_range_random block.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef LEHMER_RANGE_RANDOM_MACROS_SVH
`define LEHMER_RANGE_RANDOM_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define LRR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lehmer_range_random: assertion failed");
// Check that a consequence holds in the cycle after its trigger.
`define LRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lehmer_range_random: assertion failed");
`else
`define LRR_ASSERT(label, prop)
`define LRR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/lrr_pkg.sv
// Shared widths, constants and controller/datapath link types for lehmer_range_random.
// No dependencies.
package lrr_pkg;

  localparam int unsigned SeedW = 31;               // seed and Q0.31 fraction
  localparam int unsigned ValW  = 32;               // range bounds and result
  localparam int unsigned SpanW = 34;               // exact signed span
  localparam int unsigned ProdW = SpanW + SeedW + 1;
  localparam int unsigned SumW  = 36;               // low plus scaled draw
  localparam int unsigned MultW = 15;               // bits of the LCG multiplier

  localparam logic [SeedW-1:0]        LcgMod  = 31'h7fff_ffff;
  localparam logic signed [SpanW-1:0] LcgMult = 34'sh0_0000_41a7;

  // Input command codes.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdDraw = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul_seed;
    logic mod_seed;
    logic mul_span;
    logic out_load;
  } lrr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic seed_zero;
  } lrr_sts_t;

endpackage

>>> rtl/lehmer_range_random.sv
// lehmer_range_random: minimal standard LCG with a ranged integer draw.
// Draw: seed multiply, mod reduce, span multiply, then the sum into the output
// register; load: straight to the output register. One item at a time: a new
// item is taken only after the last is loaded out, which waits for a free output
// slot; the controller's sequence around the one shared multiplier sets this.
// Reset (async, active low): seed = 1, state machine idle, no result pending.
`include "lehmer_range_random_macros.svh"

module lehmer_range_random
  import lrr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [SeedW-1:0] seed_value_i,
  input  logic [ValW-1:0]  range_low_i,
  input  logic [ValW-1:0]  range_high_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SeedW-1:0] next_seed_o,
  output logic [ValW-1:0]  ranged_value_o
);

  lrr_cmd_t ctrl_cmd;
  lrr_sts_t dp_sts;

  lrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  lrr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .sts_o          (dp_sts),
    .in_cmd_i       (cmd_i),
    .seed_value_i   (seed_value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_seed_o    (next_seed_o),
    .ranged_value_o (ranged_value_o)
  );

  // A transaction in closes the input side in the cycle after it is accepted.
  `LRR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // Never overwrite a result that has not been taken.
  `LRR_ASSERT(a_out_load_free, !ctrl_cmd.out_load || dp_sts.out_free)
  // The reduction never leaves a zero seed.
  `LRR_ASSERT_NEXT(a_mod_nonzero, ctrl_cmd.mod_seed, !dp_sts.seed_zero)

endmodule

>>> rtl/lrr_ctrl.sv
// Sequencing state machine for lehmer_range_random.
// Depends on lrr_pkg for the command and status types.
module lrr_ctrl
  import lrr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     cmd_i,
  output logic     in_ready_o,
  input  lrr_sts_t sts_i,
  output lrr_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul1 = 5'b00010,
    StMod  = 5'b00100,
    StMul2 = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = (cmd_i == CmdDraw) ? StMul1 : StFin;
        end
      end
      StMul1: begin
        cmd_o.mul_seed = 1'b1;
        state_d        = StMod;
      end
      StMod: begin
        cmd_o.mod_seed = 1'b1;
        state_d        = StMul2;
      end
      StMul2: begin
        cmd_o.mul_span = 1'b1;
        state_d        = StFin;
      end
      StFin: begin
        // hold the result until the output slot frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/lrr_datapath.sv
// Datapath of lehmer_range_random: seed register, shared multiplier,
// mod 2^31-1 reduction, ranged sum with saturation and the output register.
// Depends on lrr_pkg.
module lrr_datapath
  import lrr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrr_cmd_t         cmd_i,
  output lrr_sts_t         sts_o,
  input  logic             in_cmd_i,
  input  logic [SeedW-1:0] seed_value_i,
  input  logic [ValW-1:0]  range_low_i,
  input  logic [ValW-1:0]  range_high_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SeedW-1:0] next_seed_o,
  output logic [ValW-1:0]  ranged_value_o
);

  logic                    draw_q;
  logic [SeedW-1:0]        seed_q, seed_d;
  logic [ValW-1:0]         low_q;
  logic signed [SpanW-1:0] span_q, span_d;
  logic signed [ProdW-1:0] prod_q, mul_p;
  logic signed [SpanW-1:0] mul_a;
  logic signed [SeedW:0]   mul_b;
  logic [SeedW:0]          red_sum, red_sub;
  logic [SeedW-1:0]        red_seed;
  logic                    round_up;
  logic [SumW-1:0]         sum;
  logic [ValW-1:0]         sat_value;
  logic                    out_valid_q;
  logic [SeedW-1:0]        out_seed_q;
  logic [ValW-1:0]         out_value_q;

  assign span_d = {{2{range_high_i[ValW-1]}}, range_high_i}
                - {{2{range_low_i[ValW-1]}}, range_low_i} + 34'sd1;

  // One multiplier: seed * 16807 first, then span * new seed.
  assign mul_a = cmd_i.mul_span ? span_q : LcgMult;
  assign mul_b = $signed({1'b0, seed_q});
  assign mul_p = mul_a * mul_b;

  // Fold the high bits back in, since 2^31 == 1 mod 2^31-1.
  assign red_sum = {1'b0, prod_q[SeedW-1:0]}
                 + {{(SeedW + 1 - MultW){1'b0}}, prod_q[SeedW+MultW-1:SeedW]};
  assign red_sub = red_sum - {1'b0, LcgMod};

  always_comb begin
    if (red_sum > {1'b0, LcgMod}) begin
      red_seed = red_sub[SeedW-1:0];
    end else if (red_sum == '0) begin
      red_seed = LcgMod;
    end else begin
      red_seed = red_sum[SeedW-1:0];
    end
  end

  // Arithmetic shift floors; add one for a negative product with a nonzero
  // fraction to truncate toward zero.
  assign round_up = prod_q[ProdW-1] & (|prod_q[SeedW-1:0]);
  assign sum = {{(SumW - ValW){low_q[ValW-1]}}, low_q}
             + {prod_q[ProdW-1], prod_q[ProdW-1:SeedW]}
             + {{(SumW - 1){1'b0}}, round_up};

  always_comb begin
    if (!sum[SumW-1] && (|sum[SumW-2:ValW-1])) begin
      sat_value = {1'b0, {(ValW - 1){1'b1}}};
    end else if (sum[SumW-1] && !(&sum[SumW-2:ValW-1])) begin
      sat_value = {1'b1, {(ValW - 1){1'b0}}};
    end else begin
      sat_value = sum[ValW-1:0];
    end
  end

  always_comb begin
    seed_d = seed_q;
    if (cmd_i.capture && (in_cmd_i == CmdLoad)) begin
      seed_d = seed_value_i;
    end else if (cmd_i.mod_seed) begin
      seed_d = red_seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= {{(SeedW - 1){1'b0}}, 1'b1};
      out_valid_q <= 1'b0;
    end else begin
      seed_q <= seed_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      draw_q <= (in_cmd_i == CmdDraw);
      low_q  <= range_low_i;
      span_q <= span_d;
    end
    if (cmd_i.mul_seed || cmd_i.mul_span) begin
      prod_q <= mul_p;
    end
    if (cmd_i.out_load) begin
      out_seed_q  <= seed_q;
      out_value_q <= draw_q ? sat_value : '0;
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.seed_zero = (seed_q == '0);

  assign out_valid_o    = out_valid_q;
  assign next_seed_o    = out_seed_q;
  assign ranged_value_o = out_value_q;

endmodule
